// ===== src/mnrs_pkg.sv =====
// Package for the median-of-N range filter.
// Holds shared constants, status codes, the controller state type and the
// controller/datapath handshake structs. No dependencies.
package mnrs_pkg;

    localparam int MAX_SAMPLES_DEF = 16;
    localparam int DIST_WIDTH_DEF  = 16;

    localparam int CFG_W    = 5;
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0] SAMPLE_COUNT_RESET = 5'd5;

    // Sensor code for "distance unknown"
    localparam int UNKNOWN_DIST = 1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_VALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TIMEOUT  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COLLECT,
        S_EMIT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take_item;
        logic open_round;
        logic emit;
    } mnrs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic round_done;
    } mnrs_stat_t;

endpackage

// ===== src/median_of_n_range_samples.sv =====
// Top level of the median-of-N range filter.
// Joins mnrs_ctrl and mnrs_datapath; uses mnrs_pkg.
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+---------------------------
//  config    | cfg_wr_en, cfg_wr_data                 | write when cfg_wr_en high
//  item in   | start, busy, distance, reading_ok      | take when start & !busy
//  result    | done, median_distance, status          | one-cycle strobe on done
//
//  The datapath inserts each item into the sorted store with a
//  compare-and-shift across all slots in the cycle that takes it.
//  After the item that closes a round, busy is high while the median
//  is read from the store and shown with done. Reset clears the
//  counters, the controller and sets the sample count to five; the store
//  needs no clearing. The receiver cannot stall, so results are never held.
module median_of_n_range_samples #(
    parameter int MAX_SAMPLES = mnrs_pkg::MAX_SAMPLES_DEF,
    parameter int DIST_WIDTH  = mnrs_pkg::DIST_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mnrs_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [DIST_WIDTH-1:0]         distance,
    input  logic                          reading_ok,
    output logic                          done,
    output logic [DIST_WIDTH-1:0]         median_distance,
    output logic [mnrs_pkg::STATUS_W-1:0] status
);
    import mnrs_pkg::*;

    // Commands down, round status up
    mnrs_cmd_t  cmd;
    mnrs_stat_t stat;

    mnrs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Store, counters and median select
    mnrs_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .DIST_WIDTH  (DIST_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .distance        (distance),
        .reading_ok      (reading_ok),
        .cmd             (cmd),
        .stat            (stat),
        .median_distance (median_distance),
        .status          (status)
    );

endmodule

// ===== src/mnrs_ctrl.sv =====
// Controller for the median-of-N range filter.
// Sequences rounds and drives the datapath commands; uses mnrs_pkg.
module mnrs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output mnrs_pkg::mnrs_cmd_t cmd,
    input  mnrs_pkg::mnrs_stat_t stat
);
    import mnrs_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        busy           = 1'b0;
        cmd.take_item  = 1'b0;
        cmd.open_round = 1'b0;
        cmd.emit       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take_item  = start;
                cmd.open_round = start;
                if (start)
                begin
                    state_next = stat.round_done ? S_EMIT : S_COLLECT;
                end
            end
            S_COLLECT:
            begin
                cmd.take_item = start;
                if (start && stat.round_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                busy       = 1'b1;
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done = cmd.emit;

    // A round result goes out for one cycle only, then the round is closed
    a_emit_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (!cmd.emit && state_reg == S_IDLE))
        else $error("result strobe held longer than one cycle");

    // A round ending on an accepted item always leads to a result
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_item && stat.round_done) |=> cmd.emit)
        else $error("round ended without a result");

    // Rounds open only from idle
    a_open_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.open_round |-> (state_reg == S_IDLE && cmd.take_item))
        else $error("round opened while one was already open");

endmodule

// ===== src/mnrs_datapath.sv =====
// Datapath for the median-of-N range filter: sample count register,
// round counters and the sorted reading store with parallel insertion.
// Uses mnrs_pkg.
module mnrs_datapath #(
    parameter int MAX_SAMPLES = mnrs_pkg::MAX_SAMPLES_DEF,
    parameter int DIST_WIDTH  = mnrs_pkg::DIST_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mnrs_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic [DIST_WIDTH-1:0]         distance,
    input  logic                          reading_ok,
    input  mnrs_pkg::mnrs_cmd_t           cmd,
    output mnrs_pkg::mnrs_stat_t          stat,
    output logic [DIST_WIDTH-1:0]         median_distance,
    output logic [mnrs_pkg::STATUS_W-1:0] status
);
    import mnrs_pkg::*;

    localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic [CFG_W-1:0]      sample_count_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         target_reg;
    logic [CW-1:0]         target_next;
    logic [STATUS_W-1:0]   err_reg;
    logic [STATUS_W-1:0]   err_next;
    logic                  any_valid_reg;
    logic                  any_valid_next;

    logic [DIST_WIDTH-1:0] store_reg  [MAX_SAMPLES];
    logic [DIST_WIDTH-1:0] store_next [MAX_SAMPLES];

    logic [CW-1:0]         clamped_count;
    logic [CW-1:0]         base_count;
    logic [CW-1:0]         base_target;
    logic [STATUS_W-1:0]   base_err;
    logic                  base_any;
    logic                  is_unknown;
    logic                  item_valid;
    logic                  insert_en;
    logic [MAX_SAMPLES-1:0] ge;
    logic [CW-1:0]         med_idx;

    // Sample count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= SAMPLE_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            sample_count_reg <= cfg_wr_data;
        end
    end

    // Zero counts as one, saturate at the store depth
    always_comb
    begin
        if (sample_count_reg == '0)
        begin
            clamped_count = CW'(1);
        end
        else if (32'(sample_count_reg) > 32'(MAX_SAMPLES))
        begin
            clamped_count = CW'(MAX_SAMPLES);
        end
        else
        begin
            clamped_count = CW'(sample_count_reg);
        end
    end

    always_comb
    begin
        if (cmd.open_round)
        begin
            base_count  = '0;
            base_target = clamped_count;
            base_err    = STATUS_OK;
            base_any    = 1'b0;
        end
        else
        begin
            base_count  = count_reg;
            base_target = target_reg;
            base_err    = err_reg;
            base_any    = any_valid_reg;
        end

        is_unknown = (distance == DIST_WIDTH'(UNKNOWN_DIST));
        item_valid = reading_ok && !is_unknown;
        insert_en  = item_valid && (base_count < CW'(MAX_SAMPLES));

        if (!reading_ok)
        begin
            err_next = STATUS_TIMEOUT;
        end
        else if (is_unknown)
        begin
            err_next = STATUS_NO_VALID;
        end
        else
        begin
            err_next = base_err;
        end

        // Drop failed attempts from the round target
        if (!item_valid && base_target != '0)
        begin
            target_next = base_target - CW'(1);
        end
        else
        begin
            target_next = base_target;
        end

        count_next      = insert_en ? (base_count + CW'(1)) : base_count;
        any_valid_next  = base_any | item_valid;
        stat.round_done = (count_next >= target_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            target_reg    <= '0;
            err_reg       <= STATUS_OK;
            any_valid_reg <= 1'b0;
        end
        else if (cmd.take_item)
        begin
            count_reg     <= count_next;
            target_reg    <= target_next;
            err_reg       <= err_next;
            any_valid_reg <= any_valid_next;
        end
    end

    // Descending store; a new value lands after any equal ones
    genvar gi;
    generate
        for (gi = 0; gi < MAX_SAMPLES; gi++)
        begin : g_slot
            logic prev_ge;
            logic [DIST_WIDTH-1:0] prev_val;

            assign ge[gi] = (store_reg[gi] >= distance);

            if (gi == 0)
            begin : g_first
                assign prev_ge  = 1'b1;
                assign prev_val = store_reg[0];
            end
            else
            begin : g_rest
                assign prev_ge  = ge[gi-1];
                assign prev_val = store_reg[gi-1];
            end

            always_comb
            begin
                store_next[gi] = store_reg[gi];
                if (cmd.take_item && insert_en)
                begin
                    if (CW'(gi) < base_count)
                    begin
                        if (!ge[gi])
                        begin
                            store_next[gi] = prev_ge ? distance : prev_val;
                        end
                    end
                    else if (CW'(gi) == base_count)
                    begin
                        store_next[gi] = prev_ge ? distance : prev_val;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                store_reg[gi] <= store_next[gi];
            end
        end
    endgenerate

    // Median pick for the closing cycle of a round
    always_comb
    begin
        med_idx = target_reg >> 1;
        if (med_idx >= count_reg)
        begin
            med_idx = count_reg - CW'(1);
        end
        if (any_valid_reg)
        begin
            median_distance = store_reg[med_idx[IW-1:0]];
            status          = STATUS_OK;
        end
        else
        begin
            median_distance = '0;
            status          = err_reg;
        end
    end

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (count_reg >= target_reg))
        else $error("result emitted before round filled");

    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_item && !stat.round_done) |=> (count_reg < target_reg))
        else $error("round counters inconsistent after item");

    a_emit_error: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !any_valid_reg) |-> (err_reg != STATUS_OK))
        else $error("failed round with no error recorded");

endmodule

// ===== tb/sv/median_of_n_range_samples_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for median_of_n_range_samples: directed and random
// range items, a round-by-round median predictor and a result scoreboard.
// Depends on mnrs_pkg and the median_of_n_range_samples RTL only.
module median_of_n_range_samples_test;

    import mnrs_pkg::*;

    localparam int DW          = DIST_WIDTH_DEF;
    localparam int STORE_DEPTH = MAX_SAMPLES_DEF;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 110;
    // Cycles to let pass after the last result before touching the register or ending the run.
    localparam int SETTLE      = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_CAP   = 20;

    // Directed items, {reading_ok, distance}, five rounds at the reset count of five.
    localparam logic [DW:0] PRIMER [25] = '{
        // extremes and duplicates in one round: median is the middle of 65535,65535,2,0,0
        {1'b1, 16'hFFFF}, {1'b1, 16'h0000}, {1'b1, 16'h0002}, {1'b1, 16'hFFFF},
        {1'b1, 16'h0000},
        // a timeout carrying the unknown code, then an unknown reading: target shrinks to 3
        {1'b0, 16'h0001}, {1'b1, 16'h0001}, {1'b1, 16'd100}, {1'b1, 16'd100},
        {1'b1, 16'd50},
        // the round closes on failed attempts, not on a valid reading
        {1'b1, 16'd10}, {1'b1, 16'd20}, {1'b1, 16'd30}, {1'b0, 16'hFFFF},
        {1'b1, 16'h0001},
        // every attempt failed, last one a timeout with the unknown code
        {1'b0, 16'd7}, {1'b1, 16'h0001}, {1'b0, 16'h0000}, {1'b1, 16'h0001},
        {1'b0, 16'h0001},
        // every attempt failed, last one an unknown reading
        {1'b0, 16'h0001}, {1'b0, 16'h8000}, {1'b0, 16'd5}, {1'b0, 16'd9},
        {1'b1, 16'h0001}
    };

    typedef struct packed {
        logic [DW-1:0]       median;
        logic [STATUS_W-1:0] status;
    } round_result_t;

    // Tracks the round in progress and holds the medians still owed by the block.
    class median_scoreboard;
        logic [DW-1:0]    store [STORE_DEPTH];
        int unsigned      kept;
        int unsigned      target;
        logic [STATUS_W-1:0] last_err;
        bit               any_valid;
        bit               round_open;
        logic [CFG_W-1:0] count_reg;
        round_result_t    owed_medians [$];
        int               errors;
        int               items;
        int               rounds_ok;
        int               rounds_no_valid;
        int               rounds_timeout;

        function new();
            kept       = 0;
            target     = 0;
            last_err   = STATUS_OK;
            any_valid  = 0;
            round_open = 0;
            count_reg  = SAMPLE_COUNT_RESET;
            errors     = 0;
            items      = 0;
            rounds_ok  = 0;
            rounds_no_valid = 0;
            rounds_timeout  = 0;
        endfunction

        function void set_count(logic [CFG_W-1:0] v);
            count_reg = v;
        endfunction

        // Advance the round by one accepted item; queue a result when it closes.
        function void note_item(logic [DW-1:0] d, logic ok);
            int unsigned   j;
            round_result_t r;
            items++;
            if (!round_open)
            begin
                round_open = 1;
                if (count_reg == '0)
                    target = 1;
                else if (32'(count_reg) > STORE_DEPTH)
                    target = STORE_DEPTH;
                else
                    target = 32'(count_reg);
                kept      = 0;
                any_valid = 0;
                last_err  = STATUS_OK;
            end
            if (!ok)
            begin
                last_err = STATUS_TIMEOUT;
                if (target > 0)
                    target--;
            end
            else if (d == DW'(UNKNOWN_DIST))
            begin
                last_err = STATUS_NO_VALID;
                if (target > 0)
                    target--;
            end
            else
            begin
                // Insert in descending order, after any equal values.
                if (kept < STORE_DEPTH)
                begin
                    j = kept;
                    while (j > 0 && store[j-1] < d)
                    begin
                        store[j] = store[j-1];
                        j--;
                    end
                    store[j] = d;
                    kept++;
                end
                any_valid = 1;
            end
            if (kept >= target)
            begin
                if (any_valid)
                begin
                    j = target >> 1;
                    if (j >= kept)
                        j = kept - 1;
                    r.median = store[j];
                    r.status = STATUS_OK;
                end
                else
                begin
                    r.median = '0;
                    r.status = last_err;
                end
                owed_medians.push_back(r);
                round_open = 0;
                kept       = 0;
                any_valid  = 0;
            end
        endfunction

        task report_mismatch(input string msg);
            if (errors < PRINT_CAP)
                $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(input logic [DW-1:0] m, input logic [STATUS_W-1:0] s);
            round_result_t want;
            if (owed_medians.size() == 0)
                report_mismatch($sformatf("result %0d/%0d with no round closed", m, s));
            else
            begin
                want = owed_medians.pop_front();
                if (m !== want.median)
                    report_mismatch($sformatf("median_distance %0d, want %0d",
                                              m, want.median));
                if (s !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", s, want.status));
                if (want.status == STATUS_OK)
                    rounds_ok++;
                else if (want.status == STATUS_NO_VALID)
                    rounds_no_valid++;
                else
                    rounds_timeout++;
            end
        endtask
    endclass

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;
    logic                start       = 1'b0;
    logic [DW-1:0]       distance    = '0;
    logic                reading_ok  = 1'b0;
    logic                busy;
    logic                done;
    logic [DW-1:0]       median_distance;
    logic [STATUS_W-1:0] status;

    median_scoreboard    sb;
    bit                  no_gaps;
    int                  cycle_count = 0;

    median_of_n_range_samples dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .start           (start),
        .busy            (busy),
        .distance        (distance),
        .reading_ok      (reading_ok),
        .done            (done),
        .median_distance (median_distance),
        .status          (status)
    );

    always #5 clk = ~clk;

    // Bound the run: a missing result otherwise hangs the drain loops.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d results owed",
                     CYCLE_LIMIT, sb.owed_medians.size());
            $display("[median_of_n_range_samples] ERROR");
            $finish;
        end
    end

    // The receiver never stalls: take every done strobe at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(median_distance, status);
    end

    // Mostly back-to-back items, some short pauses, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Draw one range item; fail_pct sets how often the attempt fails.
    function automatic void pick_item(input int fail_pct,
                                      output logic [DW-1:0] d, output logic ok);
        int r;
        r = $urandom_range(0, 99);
        if (r < fail_pct)
        begin
            // Split failures between timeouts (any distance) and unknown readings.
            ok = 1'($urandom_range(0, 1));
            if (ok)
                d = DW'(UNKNOWN_DIST);
            else
                d = ($urandom_range(0, 3) == 0) ? DW'(UNKNOWN_DIST) : DW'($urandom);
        end
        else
        begin
            ok = 1'b1;
            r  = $urandom_range(0, 99);
            if (r < 60)
                d = DW'($urandom);
            else if (r < 85)
                d = DW'($urandom_range(0, 7));   // force ties in the sorted store
            else
            begin
                case ($urandom_range(0, 3))
                    0: d = '0;
                    1: d = '1;
                    2: d = DW'(2);
                    default: d = '1 - DW'(1);
                endcase
            end
        end
    endfunction

    // Hold start and the fields until the block takes the item, then note it.
    // Start stays high on return; the caller either drives the next item in
    // the same step or lowers start.
    task automatic send_item(input logic [DW-1:0] d, input logic ok);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        distance   <= d;
        reading_ok <= ok;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(d, ok);
    endtask

    // Close any open round, drop start, and wait until every owed result is in.
    task automatic settle(input int fail_pct);
        logic [DW-1:0] d;
        logic          ok;
        while (sb.round_open)
        begin
            pick_item(fail_pct, d, ok);
            send_item(d, ok);
        end
        start <= 1'b0;
        while (sb.owed_medians.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_count(v);
    endtask

    initial
    begin
        logic [CFG_W-1:0] settings [PHASES];
        logic [DW-1:0]    d;
        logic             ok;
        int               fail_pct;

        sb = new();
        // Zero and values above the store depth are legal register contents too.
        settings = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd3, 5'd4,
                     5'd8, 5'd15, 5'd7, 5'd0};
        settings[PHASES-1] = CFG_W'($urandom_range(0, 31));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rounds run at the reset count of five.
        no_gaps = 0;
        foreach (PRIMER[i])
            send_item(PRIMER[i][DW-1:0], PRIMER[i][DW]);
        settle(0);

        // Random phases: one register setting each, failure rate cycling from
        // rare to heavy, with the occasional phase of back-to-back items.
        for (int p = 0; p < PHASES; p++)
        begin
            write_count(settings[p]);
            case (p % 4)
                0: fail_pct = 5;
                1: fail_pct = 25;
                2: fail_pct = 60;
                default: fail_pct = 0;
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick_item(fail_pct, d, ok);
                send_item(d, ok);
            end
            settle(fail_pct);
        end

        $display("covered %0d items over %0d sample-count settings plus reset",
                 sb.items, PHASES);
        $display("rounds checked: %0d median, %0d no-valid, %0d timed out; %0d mismatches",
                 sb.rounds_ok, sb.rounds_no_valid, sb.rounds_timeout, sb.errors);
        if (sb.errors == 0 && sb.owed_medians.size() == 0)
            $display("[median_of_n_range_samples] OK");
        else
            $display("[median_of_n_range_samples] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/mnrs_pkg.sv
src/mnrs_ctrl.sv
src/mnrs_datapath.sv
src/median_of_n_range_samples.sv
tb/sv/median_of_n_range_samples_test.sv
